/* rtl/core/digit_trie_prefix_check_core_macros.svh */
// assertion macros for the digit trie prefix check core
`ifndef DIGIT_TRIE_PREFIX_CHECK_CORE_MACROS_SVH
`define DIGIT_TRIE_PREFIX_CHECK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dtpc_pkg.sv */
// shared types and constants of the digit trie prefix check core
`default_nettype none
package dtpc_pkg;

  localparam int DIGIT_W = 4;

  // bit positions inside a node flag entry
  localparam int END_BIT = 1;
  localparam int HAS_BIT = 0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic clear;
    logic rd_cur;
    logic eval;
    logic alloc;
    logic overflow;
    logic follow;
    logic zero_wr;
    logic final_mark;
    logic emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_clear;
    logic digit_ok;
    logic is_last;
    logic dropped;
    logic child_zero;
    logic pool_exhausted;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/dtpc_ctrl.sv */
// controller state machine of the digit trie prefix check core
`default_nettype none
module dtpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dtpc_pkg::sts_t sts,
  output dtpc_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_EVAL     = 3'd3;
  localparam logic [2:0] S_ZERO     = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_clear) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (!sts.digit_ok) begin
          state_next = S_IDLE;
        end else if (sts.dropped) begin
          state_next = sts.is_last ? S_EMIT : S_IDLE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.child_zero) begin
          if (sts.pool_exhausted) begin
            cmd.overflow = 1'b1;
            state_next   = sts.is_last ? S_EMIT : S_IDLE;
          end else begin
            cmd.alloc  = 1'b1;
            state_next = S_ZERO;
          end
        end else begin
          cmd.follow = 1'b1;
          state_next = sts.is_last ? S_FINAL : S_IDLE;
        end
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        state_next  = sts.is_last ? S_EMIT : S_IDLE;
      end
      S_FINAL: begin
        cmd.final_mark = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dtpc_datapath.sv */
// node tables, walk registers and result register of the digit trie prefix check core
`default_nettype none
module dtpc_datapath #(
  parameter int NODE_POOL = 16384,
  parameter int RADIX     = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dtpc_pkg::cmd_t                cmd,
  output dtpc_pkg::sts_t                     sts,
  input  wire logic                          op,
  input  wire logic [dtpc_pkg::DIGIT_W-1:0]  digit,
  input  wire logic                          last_digit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               prefix_conflict,
  output logic                               pool_full
);

  localparam int NW = $clog2(NODE_POOL);
  localparam int CW = $clog2(NODE_POOL + 1);
  localparam int SW = $clog2(RADIX);

  typedef logic [RADIX-1:0][NW-1:0] row_t;

  row_t       child_mem [NODE_POOL];
  logic [1:0] flag_mem  [NODE_POOL];

  logic                         op_q;
  logic [dtpc_pkg::DIGIT_W-1:0] digit_q;
  logic                         last_q;
  logic [NW-1:0]                cur;
  logic [NW-1:0]                new_node;
  logic [CW-1:0]                nodes_used;
  logic                         conflict_seen;
  logic                         overflow_seen;
  logic                         dropped;
  row_t                         row_rd;
  logic [1:0]                   flag_rd;

  logic [SW-1:0] slot;
  logic [NW-1:0] child;
  row_t          row_upd;

  logic          row_we;
  logic [NW-1:0] row_waddr;
  row_t          row_wdata;
  logic          flag_we;
  logic [NW-1:0] flag_waddr;
  logic [1:0]    flag_wdata;
  logic          flag_re;
  logic [NW-1:0] flag_raddr;

  assign slot  = digit_q[SW-1:0];
  assign child = row_rd[slot];

  always_comb begin
    row_upd       = row_rd;
    row_upd[slot] = nodes_used[NW-1:0];
  end

  assign sts.is_clear       = op_q;
  assign sts.digit_ok       = ({1'b0, digit_q} < (dtpc_pkg::DIGIT_W + 1)'(RADIX));
  assign sts.is_last        = last_q;
  assign sts.dropped        = dropped;
  assign sts.child_zero     = (child == '0);
  assign sts.pool_exhausted = (nodes_used >= CW'(NODE_POOL));
  assign sts.out_busy       = out_valid & ~out_ready;

  // write port selection, one writer per cycle by construction
  always_comb begin
    row_we     = 1'b0;
    row_waddr  = cur;
    row_wdata  = '0;
    flag_we    = 1'b0;
    flag_waddr = cur;
    flag_wdata = 2'b00;
    if (cmd.clear) begin
      row_we     = 1'b1;
      row_waddr  = '0;
      flag_we    = 1'b1;
      flag_waddr = '0;
    end else if (cmd.alloc) begin
      row_we                       = 1'b1;
      row_wdata                    = row_upd;
      flag_we                      = 1'b1;
      flag_wdata[dtpc_pkg::END_BIT] = flag_rd[dtpc_pkg::END_BIT];
      flag_wdata[dtpc_pkg::HAS_BIT] = 1'b1;
    end else if (cmd.zero_wr) begin
      row_we                       = 1'b1;
      row_waddr                    = new_node;
      flag_we                      = 1'b1;
      flag_waddr                   = new_node;
      flag_wdata[dtpc_pkg::END_BIT] = last_q;
    end else if (cmd.final_mark) begin
      flag_we                      = 1'b1;
      flag_wdata[dtpc_pkg::END_BIT] = 1'b1;
      flag_wdata[dtpc_pkg::HAS_BIT] = flag_rd[dtpc_pkg::HAS_BIT];
    end
  end

  assign flag_re    = cmd.rd_cur | cmd.follow;
  assign flag_raddr = cmd.follow ? child : cur;

  always_ff @(posedge clk) begin
    if (row_we) begin
      child_mem[row_waddr] <= row_wdata;
    end
    if (cmd.rd_cur) begin
      row_rd <= child_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (flag_re) begin
      flag_rd <= flag_mem[flag_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op;
      digit_q <= digit;
      last_q  <= last_digit;
    end
    if (cmd.alloc) begin
      new_node <= nodes_used[NW-1:0];
    end
    if (cmd.emit) begin
      prefix_conflict <= conflict_seen;
      pool_full       <= overflow_seen;
    end
  end

  // walk and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      nodes_used    <= CW'(1);
      conflict_seen <= 1'b0;
      overflow_seen <= 1'b0;
      dropped       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cur           <= '0;
        nodes_used    <= CW'(1);
        conflict_seen <= 1'b0;
        overflow_seen <= 1'b0;
        dropped       <= 1'b0;
      end
      if (cmd.eval && flag_rd[dtpc_pkg::END_BIT]) begin
        conflict_seen <= 1'b1;
      end
      if (cmd.alloc) begin
        nodes_used <= nodes_used + CW'(1);
      end
      if (cmd.overflow) begin
        overflow_seen <= 1'b1;
        dropped       <= 1'b1;
      end
      if (cmd.follow) begin
        cur <= child;
      end
      if (cmd.zero_wr) begin
        cur <= new_node;
      end
      if (cmd.final_mark &&
          (flag_rd[dtpc_pkg::END_BIT] || flag_rd[dtpc_pkg::HAS_BIT])) begin
        conflict_seen <= 1'b1;
      end
      if (cmd.emit) begin
        cur       <= '0;
        dropped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/digit_trie_prefix_check_core.sv */
// top level of the digit trie prefix check core
`default_nettype none
`include "digit_trie_prefix_check_core_macros.svh"

// checks a list of decimal numbers for the prefix-free property, one digit
// per input word. op = 1 clears the trie and starts a new list; op = 0 feeds
// one digit, and last_digit closes the number. only the word carrying
// last_digit returns a result word: prefix_conflict (some number of the list
// is a prefix of another so far) and pool_full (a node allocation failed
// since the last clear), both sticky until the next clear. digits of RADIX
// or more are dropped without a result. after the pool runs out, the rest of
// the current number is skipped but its last digit still returns the flags.
// flow: the block takes one word at a time. a digit on an existing path
// passes accept, row read and evaluate; allocating a node adds a state that
// zeroes the new node, closing a number on an existing node adds one that
// marks it, and a closing digit then loads the result register once the
// previous result is taken. a clear passes accept and dispatch. the child
// rows have one write port, so the parent row and the new row are written in
// separate cycles. the input side keeps running while a result waits for
// out_ready, up to the next closing digit. after reset the init state
// empties the root before the first word is taken; no other clearing pass
// is needed because a node's row is zeroed when it is allocated.
module digit_trie_prefix_check_core #(
  parameter int NODE_POOL = 16384,
  parameter int RADIX     = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [dtpc_pkg::DIGIT_W-1:0]  digit,
  input  wire logic                          last_digit,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               prefix_conflict,
  output logic                               pool_full
);

  // command and status between the sequencer and the tables
  dtpc_pkg::cmd_t cmd;
  dtpc_pkg::sts_t sts;

  // sequencer: dispatch, row read, evaluate, allocate or mark, emit
  dtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // child rows, node flags, walk pointer, counters and result register
  dtpc_datapath #(
    .NODE_POOL (NODE_POOL),
    .RADIX     (RADIX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .op              (op),
    .digit           (digit),
    .last_digit      (last_digit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .prefix_conflict (prefix_conflict),
    .pool_full       (pool_full)
  );

  // one word in flight: the cycle after an accept the input side is closed
  `DTPC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "word accepted while busy")
  // loading the result register always raises out_valid
  `DTPC_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "result load lost")
  // a node is never allocated from an exhausted pool
  `DTPC_ASSERT_NOW(a_alloc_room, cmd.alloc, !sts.pool_exhausted, "allocation past pool end")
  // a result is never loaded over one that is still waiting
  `DTPC_ASSERT_NOW(a_no_overrun, cmd.emit, !(out_valid && !out_ready), "result overrun")

endmodule
`default_nettype wire

/* bench/trie_check_pkg.sv */
// scoreboard and shared constants for the digit trie prefix check bench
package trie_check_pkg;

  // small pool so that exhaustion shows up within a short run
  localparam int POOL_NODES  = 128;
  localparam int DIGIT_RADIX = 10;
  localparam int NODE_W      = 14;
  localparam int COUNT_W     = 15;

  typedef enum logic {
    OP_DIGIT = 1'b0,
    OP_CLEAR = 1'b1
  } word_op_e;

  typedef struct packed {
    logic conflict;
    logic full;
  } trie_flags_t;

  class trie_scoreboard;
    logic [NODE_W-1:0]  kids [POOL_NODES*DIGIT_RADIX];
    bit                 end_mark [POOL_NODES];
    bit                 has_kid [POOL_NODES];
    logic [COUNT_W-1:0] nodes_used;
    logic [NODE_W-1:0]  cur_node;
    bit                 conflict_seen;
    bit                 overflow_seen;
    bit                 walk_dropped;
    trie_flags_t        flags_due [$];
    int                 errors;
    int                 words_seen;
    int                 results_checked;
    int                 conflict_results;
    int                 full_results;
    int                 clears_seen;

    function new();
      foreach (kids[i]) kids[i] = '0;
      errors = 0;
      words_seen = 0;
      results_checked = 0;
      conflict_results = 0;
      full_results = 0;
      clears_seen = 0;
      start_list();
    endfunction

    function void empty_node(int n);
      for (int d = 0; d < DIGIT_RADIX; d++) kids[n*DIGIT_RADIX+d] = '0;
      end_mark[n] = 1'b0;
      has_kid[n] = 1'b0;
    endfunction

    function void start_list();
      empty_node(0);
      nodes_used = 1;
      cur_node = '0;
      conflict_seen = 1'b0;
      overflow_seen = 1'b0;
      walk_dropped = 1'b0;
    endfunction

    // walk one accepted word through the trie, queue a flag pair on a last digit
    function void note_word(word_op_e w_op, logic [3:0] w_digit, logic w_last);
      int                slot;
      logic [NODE_W-1:0] nxt;
      trie_flags_t       due;
      words_seen++;
      if (w_op == OP_CLEAR) begin
        start_list();
        clears_seen++;
        return;
      end
      if (int'(w_digit) >= DIGIT_RADIX) return;
      if (!walk_dropped) begin
        if (end_mark[cur_node]) conflict_seen = 1'b1;
        slot = int'(cur_node) * DIGIT_RADIX + int'(w_digit);
        nxt = kids[slot];
        if (nxt == '0) begin
          if (int'(nodes_used) >= POOL_NODES) begin
            overflow_seen = 1'b1;
            walk_dropped = 1'b1;
          end else begin
            nxt = nodes_used[NODE_W-1:0];
            nodes_used++;
            empty_node(int'(nxt));
            kids[slot] = nxt;
            has_kid[cur_node] = 1'b1;
          end
        end
        if (!walk_dropped) begin
          cur_node = nxt;
          if (w_last) begin
            if (end_mark[nxt] || has_kid[nxt]) conflict_seen = 1'b1;
            end_mark[nxt] = 1'b1;
          end
        end
      end
      if (!w_last) return;
      cur_node = '0;
      walk_dropped = 1'b0;
      due.conflict = conflict_seen;
      due.full = overflow_seen;
      flags_due.push_back(due);
    endfunction

    function void check_result(logic got_conflict, logic got_full);
      trie_flags_t due;
      if (flags_due.size() == 0) begin
        $error("result word with nothing expected: prefix_conflict %0b pool_full %0b",
               got_conflict, got_full);
        errors++;
        return;
      end
      due = flags_due.pop_front();
      results_checked++;
      if (due.conflict) conflict_results++;
      if (due.full) full_results++;
      if (got_conflict !== due.conflict) begin
        $error("prefix_conflict: expected %0b, actual %0b", due.conflict, got_conflict);
        errors++;
      end
      if (got_full !== due.full) begin
        $error("pool_full: expected %0b, actual %0b", due.full, got_full);
        errors++;
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

endpackage

/* bench/tb.sv */
// top of the digit trie prefix check bench: clock, drivers, monitor, stimulus
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trie_check_pkg::*;

  localparam int RANDOM_WORDS  = 1250;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HIST_DEPTH    = 64;
  localparam int NUM_MAX       = 32;
  localparam int ASCII_ZERO    = 48;

  logic       clk;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic       op         = OP_DIGIT;
  logic [3:0] digit      = '0;
  logic       last_digit = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic       prefix_conflict;
  logic       pool_full;

  trie_scoreboard sb;

  // sender burst state
  int burst_left = 0;
  bit gap_free   = 1'b0;
  int useful_words = 0;

  // receiver long hold-off handshake between the two processes
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  // number under construction and numbers already in the current list
  logic [3:0] num_buf [NUM_MAX];
  int         num_len;
  logic [3:0] hist_num [HIST_DEPTH][NUM_MAX];
  int         hist_len [HIST_DEPTH];
  int         hist_cnt = 0;

  digit_trie_prefix_check_core #(
    .NODE_POOL (POOL_NODES),
    .RADIX     (DIGIT_RADIX)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .digit           (digit),
    .last_digit      (last_digit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .prefix_conflict (prefix_conflict),
    .pool_full       (pool_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor: every accepted word feeds the predictor, every result is checked
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (in_valid && in_ready) sb.note_word(word_op_e'(op), digit, last_digit);
      if (out_valid && out_ready) sb.check_result(prefix_conflict, pool_full);
    end
  end

  // watchdog: too many cycles in a row with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: rotating stall pattern plus one long hold-off on request
  initial begin
    int rx_cycle;
    int stall_left;
    rx_cycle = 0;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // block fills up behind the pending result and stalls its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else begin
        rx_cycle++;
        case ((rx_cycle / 97) % 4)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= (rx_cycle % 5) != 0;
          end
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else begin
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(3, 25);
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // offer one word, hold it until taken, then maybe open a gap
  task automatic send_word(word_op_e w_op, logic [3:0] w_digit, logic w_last);
    int gap;
    in_valid   <= 1'b1;
    op         <= w_op;
    digit      <= w_digit;
    last_digit <= w_last;
    do @(posedge clk); while (!in_ready);
    // out-of-range digits are dropped by the block and do not count
    if (w_op == OP_CLEAR || int'(w_digit) < DIGIT_RADIX) useful_words++;
    gap = 0;
    if (burst_left == 0) begin
      gap_free = ($urandom_range(0, 3) == 0);
      gap = gap_free ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    hist_cnt = 0;
  endtask

  function automatic void load_digits(string s);
    num_len = s.len();
    for (int i = 0; i < num_len; i++) num_buf[i] = 4'(int'(s[i]) - ASCII_ZERO);
  endfunction

  // send num_buf as one number; with noise, sprinkle dropped digits and broken numbers
  task automatic emit_number(bit noisy);
    int slot;
    for (int i = 0; i < num_len; i++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_word(OP_DIGIT, 4'($urandom_range(DIGIT_RADIX, 15)), 1'($urandom_range(0, 1)));
      if (noisy && i > 0 && $urandom_range(0, 39) == 0) begin
        // clear in the middle of a number abandons it
        send_clear();
        return;
      end
      send_word(OP_DIGIT, num_buf[i], i == num_len - 1);
    end
    if (hist_cnt < HIST_DEPTH) begin
      slot = hist_cnt;
      hist_cnt++;
    end else begin
      slot = $urandom_range(0, HIST_DEPTH - 1);
    end
    hist_len[slot] = num_len;
    for (int i = 0; i < num_len; i++) hist_num[slot][i] = num_buf[i];
  endtask

  // build a number that is fresh, or a prefix, extension or copy of an earlier one
  task automatic pick_number();
    int kind;
    int src;
    int extra;
    int hi;
    kind = $urandom_range(0, 99);
    src = (hist_cnt > 0) ? $urandom_range(0, hist_cnt - 1) : 0;
    if (hist_cnt == 0 || kind < 50 || kind >= 90) begin
      num_len = ($urandom_range(0, 32) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      // narrow alphabets make paths share nodes
      hi = (kind >= 90) ? 1 : (($urandom_range(0, 1) == 1) ? DIGIT_RADIX - 1 : 2);
      for (int i = 0; i < num_len; i++) num_buf[i] = 4'($urandom_range(0, hi));
    end else begin
      num_len = hist_len[src];
      for (int i = 0; i < num_len; i++) num_buf[i] = hist_num[src][i];
      if (kind < 65) begin
        num_len = $urandom_range(1, num_len);
      end else if (kind < 80) begin
        extra = $urandom_range(1, 3);
        for (int i = 0; i < extra && num_len < NUM_MAX; i++) begin
          num_buf[num_len] = 4'($urandom_range(0, DIGIT_RADIX - 1));
          num_len++;
        end
      end
    end
  endtask

  initial begin
    int list_len;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single digits at both ends, prefix on the path, end on a node
    // with children, duplicates, dropped digits with and without last_digit
    send_word(OP_CLEAR, 4'd0, 1'b0);
    load_digits("0");
    emit_number(1'b0);
    load_digits("9");
    emit_number(1'b0);
    load_digits("01");
    emit_number(1'b0);
    send_word(OP_CLEAR, 4'd15, 1'b1);
    send_word(OP_DIGIT, 4'd15, 1'b1);
    send_word(OP_DIGIT, 4'd10, 1'b0);
    load_digits("555");
    emit_number(1'b0);
    load_digits("55");
    emit_number(1'b0);
    send_word(OP_CLEAR, 4'd9, 1'b0);
    load_digits("123");
    emit_number(1'b0);
    load_digits("124");
    emit_number(1'b0);
    load_digits("7");
    emit_number(1'b0);
    load_digits("7");
    emit_number(1'b0);
    send_word(OP_CLEAR, 4'd0, 1'b1);
    hist_cnt = 0;

    // random lists: mostly well-formed numbers, some noise and broken numbers;
    // long lists run the small pool dry
    useful_words = 0;
    while (useful_words < RANDOM_WORDS) begin
      send_clear();
      list_len = $urandom_range(2, 40);
      for (int n = 0; n < list_len && useful_words < RANDOM_WORDS; n++) begin
        if (useful_words >= 400) hold_req = 1'b1;
        pick_number();
        emit_number(1'b1);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("run covered %0d words and %0d list clears; %0d results checked",
             sb.words_seen, sb.clears_seen, sb.results_checked);
    $display("%0d results flagged a prefix conflict, %0d flagged a full pool",
             sb.conflict_results, sb.full_results);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dtpc_pkg.sv
rtl/core/dtpc_ctrl.sv
rtl/core/dtpc_datapath.sv
rtl/core/digit_trie_prefix_check_core.sv
bench/trie_check_pkg.sv
bench/tb.sv
